// ===== rtl/rrsc_pkg.sv =====
// Shared constants, types and handshake structs for the rounded-rect span clipper.
package rrsc_pkg;

  localparam int COORD_MAX = 4096;
  localparam int RAD_MAX   = COORD_MAX / 2;
  localparam int CW        = $clog2(COORD_MAX) + 1;  // coordinate register width
  localparam int RW        = CW - 1;                 // radius / screen column width
  localparam int XW        = CW + 2;                 // signed working width
  localparam int SQ_W      = 2 * RW;                 // radicand width
  localparam int CFG_IW    = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RECT_X        = 3'd0,
    CFG_RECT_Y        = 3'd1,
    CFG_RECT_W        = 3'd2,
    CFG_RECT_H        = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_SCREEN_WIDTH  = 3'd5,
    CFG_SCREEN_HEIGHT = 3'd6,
    CFG_SOURCE_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_DY    = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_WAIT  = 9'b000100000,
    S_CLIP1 = 9'b001000000,
    S_CLIP2 = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] n;
  } sqrt_req_t;

  typedef struct packed {
    logic          done;
    logic [RW-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== rtl/rrsc_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module rrsc_isqrt import rrsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic [SQ_W-1:0] n_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic            done_r;
  logic [SQ_W:0]   trial;
  logic            fits;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign fits  = {1'b0, n_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        n_r   <= req.n;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
      end else if (bit_r != '0) begin
        if (fits) begin
          n_r   <= n_r - trial[SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        done_r <= (bit_r == SQ_W'(1));
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[RW-1:0];

endmodule

// ===== rtl/rounded_rect_span_clip.sv =====
// Top level: register file, row sequencer and span clipping around the shared square root.
//
//  channel | ports                                         | dir | handshake
//  --------+-----------------------------------------------+-----+----------------------
//  in      | in_row                                        | in  | in_valid / in_ready
//  out     | out_visible out_dest_x out_dest_y out_src_x   | out | out_valid / out_ready
//          | out_span_len                                  |     |
//  cfg     | cfg_index cfg_data                            | in  | cfg_valid / cfg_ready
//
// A corner-band row passes PREP, DY, MUL, ROOT, WAIT (the bit-serial square root),
// CLIP1, CLIP2 and FIN; full-width rows go from PREP to CLIP1, invisible rows to FIN.
// in_ready is high only in the idle state; a finished item waits in the output
// register, and the next item is accepted meanwhile. The sequencer holds its
// result until the output register is free. cfg_ready is always high.
// Reset is synchronous; all configuration registers clear to zero.
module rounded_rect_span_clip import rrsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RW-1:0]     in_row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_visible,
  output logic [RW-1:0]     out_dest_x,
  output logic [RW-1:0]     out_dest_y,
  output logic [CW-1:0]     out_src_x,
  output logic [CW-1:0]     out_span_len,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data
);

  // configuration
  logic signed [CW-1:0] rect_x_r, rect_y_r;
  logic [CW-1:0]        rect_w_r, rect_h_r, sw_r, sh_r, srch_r;
  logic [RW-1:0]        cr_r;
  logic [CW-1:0]        cfg_sat;
  logic [RW-1:0]        cfg_rad;

  state_t state_r, state_nxt;

  // per-item work registers
  logic [RW-1:0]          row_r;
  logic signed [XW-1:0]   sy_r;
  logic [RW-1:0]          rc_r;
  logic [CW-1:0]          dyabs_r;
  logic [SQ_W-1:0]        r2_r;
  logic [SQ_W:0]          d2_r;
  logic signed [XW-1:0]   x0_r, dx_r, len_r, e_r;
  logic                   empty_r;
  logic                   vis_r;
  logic [RW-1:0]          dxo_r;
  logic [CW-1:0]          srcx_r, leno_r;

  logic                   out_valid_r;
  logic                   out_visible_r;
  logic [RW-1:0]          out_dest_x_r, out_dest_y_r;
  logic [CW-1:0]          out_src_x_r, out_span_len_r;

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  rrsc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  // signed views of the unsigned registers
  logic signed [XW-1:0] y_s, h_s, w_s, r_s, sw_s, sh_s, srch_s, rc_s, rx_s;
  assign y_s    = signed'(XW'(row_r));
  assign h_s    = signed'(XW'(rect_h_r));
  assign w_s    = signed'(XW'(rect_w_r));
  assign r_s    = signed'(XW'(cr_r));
  assign sw_s   = signed'(XW'(sw_r));
  assign sh_s   = signed'(XW'(sh_r));
  assign srch_s = signed'(XW'(srch_r));
  assign rc_s   = signed'(XW'(rc_r));
  assign rx_s   = XW'(rect_x_r);

  // PREP: visibility, band test on the raw radius, radius clamp
  logic signed [XW-1:0] sy_c;
  logic                 inv_c, full_c;
  logic [RW-1:0]        r1_c, rc_c;
  assign sy_c   = XW'(rect_y_r) + y_s;
  assign inv_c  = (y_s >= h_s) || (sy_c < 0) || (sy_c >= sh_s) || (y_s >= srch_s);
  assign full_c = (cr_r == '0) || ((y_s >= r_s) && (y_s < h_s - r_s));
  assign r1_c   = ({1'b0, cr_r, 1'b0} > {1'b0, rect_w_r}) ? RW'(rect_w_r >> 1) : cr_r;
  assign rc_c   = ({1'b0, r1_c, 1'b0} > {1'b0, rect_h_r}) ? RW'(rect_h_r >> 1) : r1_c;

  // DY: vertical distance to the corner center
  logic signed [XW-1:0] cy_c, dy_c, dya_c;
  assign cy_c  = (y_s < rc_s) ? rc_s : (h_s - XW'(1) - rc_s);
  assign dy_c  = y_s - cy_c;
  assign dya_c = (dy_c < 0) ? -dy_c : dy_c;

  // ROOT: radicand, zero when the row is outside the circle
  logic [SQ_W-1:0] n_c;
  assign n_c = (d2_r <= {1'b0, r2_r}) ? (r2_r - d2_r[SQ_W-1:0]) : '0;

  assign sq_req.start = (state_r == S_ROOT);
  assign sq_req.n     = n_c;

  // CLIP2: left then right clip; after a left clip the span ends at e_r
  logic                 neg_c, over_c, vis_c;
  logic signed [XW-1:0] dxp_c, srcx_c, lenl_c, lenc_c;
  assign neg_c  = dx_r < 0;
  assign dxp_c  = neg_c ? '0 : dx_r;
  assign srcx_c = neg_c ? (x0_r - dx_r) : x0_r;
  assign lenl_c = neg_c ? e_r : len_r;
  assign over_c = e_r > sw_s;
  assign lenc_c = over_c ? (sw_s - dxp_c) : lenl_c;
  assign vis_c  = !empty_r && (lenc_c > 0);

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_PREP;
      S_PREP: begin
        if (inv_c)       state_nxt = S_FIN;
        else if (full_c) state_nxt = S_CLIP1;
        else             state_nxt = S_DY;
      end
      S_DY:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ROOT;
      S_ROOT:  state_nxt = S_WAIT;
      S_WAIT:  if (sq_rsp.done) state_nxt = S_CLIP1;
      S_CLIP1: state_nxt = S_CLIP2;
      S_CLIP2: state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_sat = (cfg_data > CW'(COORD_MAX)) ? CW'(COORD_MAX) : cfg_data;
  assign cfg_rad = (cfg_data[RW-1:0] > RW'(RAD_MAX)) ? RW'(RAD_MAX) : cfg_data[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rect_x_r    <= '0;
      rect_y_r    <= '0;
      rect_w_r    <= '0;
      rect_h_r    <= '0;
      cr_r        <= '0;
      sw_r        <= '0;
      sh_r        <= '0;
      srch_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RECT_X:        rect_x_r <= signed'(cfg_data);
          CFG_RECT_Y:        rect_y_r <= signed'(cfg_data);
          CFG_RECT_W:        rect_w_r <= cfg_sat;
          CFG_RECT_H:        rect_h_r <= cfg_sat;
          CFG_CORNER_RADIUS: cr_r     <= cfg_rad;
          CFG_SCREEN_WIDTH:  sw_r     <= cfg_sat;
          CFG_SCREEN_HEIGHT: sh_r     <= cfg_sat;
          CFG_SOURCE_HEIGHT: srch_r   <= cfg_sat;
          default: ;
        endcase
      end

      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end

    case (state_r)
      S_IDLE: row_r <= in_row;
      S_PREP: begin
        sy_r   <= sy_c;
        rc_r   <= rc_c;
        x0_r   <= '0;
        vis_r  <= 1'b0;
      end
      S_DY:   dyabs_r <= dya_c[CW-1:0];
      S_MUL: begin
        r2_r <= SQ_W'(rc_r) * SQ_W'(rc_r);
        d2_r <= (SQ_W+1)'(dyabs_r) * (SQ_W+1)'(dyabs_r);
      end
      S_WAIT: if (sq_rsp.done) x0_r <= rc_s - signed'(XW'(sq_rsp.root));
      S_CLIP1: begin
        empty_r <= (x0_r <<< 1) >= w_s;
        dx_r    <= rx_s + x0_r;
        len_r   <= w_s - (x0_r <<< 1);
        e_r     <= rx_s + w_s - x0_r;
      end
      S_CLIP2: begin
        vis_r  <= vis_c;
        dxo_r  <= dxp_c[RW-1:0];
        srcx_r <= srcx_c[CW-1:0];
        leno_r <= lenc_c[CW-1:0];
      end
      S_FIN: begin
        if (out_free) begin
          out_visible_r  <= vis_r;
          out_dest_x_r   <= vis_r ? dxo_r : '0;
          out_dest_y_r   <= vis_r ? sy_r[RW-1:0] : '0;
          out_src_x_r    <= vis_r ? srcx_r : '0;
          out_span_len_r <= vis_r ? leno_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_dest_x   = out_dest_x_r;
  assign out_dest_y   = out_dest_y_r;
  assign out_src_x    = out_src_x_r;
  assign out_span_len = out_span_len_r;

  // an accepted item keeps in_ready low in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // invisible results carry all-zero fields
  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |->
      out_dest_x == '0 && out_dest_y == '0 && out_src_x == '0 && out_span_len == '0)
    else $error("invisible item with nonzero fields");

  // a visible span is nonempty and stays on screen
  a_span_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |->
      out_span_len != '0 &&
      ((CW+1)'(out_dest_x) + (CW+1)'(out_span_len) <= (CW+1)'(sw_r)))
    else $error("visible span off screen or empty");

  // the root unit only finishes while the sequencer waits for it
  a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_rsp.done |-> state_r == S_WAIT)
    else $error("square root finished outside wait state");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the rounded-rect span clipper: queued row driver, result monitor.
module tb;
  import rrsc_pkg::*;

  typedef struct packed {
    logic          visible;
    logic [RW-1:0] dest_x;
    logic [RW-1:0] dest_y;
    logic [CW-1:0] src_x;
    logic [CW-1:0] span_len;
  } span_t;

  localparam int STUCK_LIMIT = 3000;
  localparam int SETTLE      = 30;
  localparam int RANDOM_ROWS = 1800;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [RW-1:0]     in_row = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_visible;
  logic [RW-1:0]     out_dest_x;
  logic [RW-1:0]     out_dest_y;
  logic [CW-1:0]     out_src_x;
  logic [CW-1:0]     out_span_len;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CW-1:0]     cfg_data = '0;

  rounded_rect_span_clip dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // layer geometry as the block should currently see it
  longint lay_x, lay_y, lay_w, lay_h, lay_rad, scr_w, scr_h, src_h;

  logic [RW-1:0] rows_pending[$];
  span_t         spans_due[$];
  int            errors = 0;
  int            spans_seen = 0;
  int            stuck = 0;
  bit            calm = 1'b0;
  int            tx_wait, rx_wait;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CW-1:0] val);
    longint u;
    u = val;
    case (idx)
      CFG_RECT_X:        lay_x = longint'($signed(val));
      CFG_RECT_Y:        lay_y = longint'($signed(val));
      CFG_RECT_W:        lay_w = (u > COORD_MAX) ? COORD_MAX : u;
      CFG_RECT_H:        lay_h = (u > COORD_MAX) ? COORD_MAX : u;
      CFG_CORNER_RADIUS: lay_rad = (val[RW-1:0] > RAD_MAX) ? RAD_MAX : val[RW-1:0];
      CFG_SCREEN_WIDTH:  scr_w = (u > COORD_MAX) ? COORD_MAX : u;
      CFG_SCREEN_HEIGHT: scr_h = (u > COORD_MAX) ? COORD_MAX : u;
      CFG_SOURCE_HEIGHT: src_h = (u > COORD_MAX) ? COORD_MAX : u;
      default: ;
    endcase
  endfunction

  // largest root with root*root <= n
  function automatic longint floor_root(longint n);
    longint res, t;
    res = 0;
    for (int b = 12; b >= 0; b--) begin
      t = res | (longint'(1) << b);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  function automatic span_t row_span(logic [RW-1:0] row);
    longint y, r, sy, x0, x1, cy, dy, ins, dx, len;
    span_t s;
    s = '0;
    y = row;
    r = lay_rad;
    sy = lay_y + y;
    if (y >= lay_h || sy < 0 || sy >= scr_h || y >= src_h) return s;
    // band test takes the radius before clamping
    if (r <= 0 || (y >= r && y < lay_h - r)) begin
      x0 = 0;
      x1 = lay_w;
    end else begin
      if (r * 2 > lay_w) r = lay_w / 2;
      if (r * 2 > lay_h) r = lay_h / 2;
      cy = (y < r) ? r : lay_h - 1 - r;
      dy = y - cy;
      ins = (dy * dy <= r * r) ? floor_root(r * r - dy * dy) : 0;
      x0 = r - ins;
      x1 = lay_w - (r - ins);
      if (x0 < 0) x0 = 0;
      if (x1 > lay_w) x1 = lay_w;
    end
    if (x0 >= x1) return s;
    dx = lay_x + x0;
    len = x1 - x0;
    if (dx < 0) begin
      x0 -= dx;
      len += dx;
      dx = 0;
    end
    if (dx + len > scr_w) len = scr_w - dx;
    if (len <= 0) return s;
    s.visible  = 1'b1;
    s.dest_x   = dx[RW-1:0];
    s.dest_y   = sy[RW-1:0];
    s.src_x    = x0[CW-1:0];
    s.span_len = len[CW-1:0];
    return s;
  endfunction

  // row driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) spans_due.push_back(row_span(in_row));
      if (in_valid && !in_ready) begin
        // hold the item
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (rows_pending.size() > 0) begin
        in_row <= rows_pending.pop_front();
        in_valid <= 1'b1;
        tx_wait = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    span_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_visible, out_dest_x, out_dest_y, out_src_x, out_span_len};
        spans_seen++;
        if (spans_due.size() == 0) begin
          report("span result with no row outstanding");
        end else begin
          want = spans_due.pop_front();
          if (got.visible !== want.visible)
            report($sformatf("visible got %0d want %0d", got.visible, want.visible));
          if (got.dest_x !== want.dest_x)
            report($sformatf("dest_x got %0d want %0d", got.dest_x, want.dest_x));
          if (got.dest_y !== want.dest_y)
            report($sformatf("dest_y got %0d want %0d", got.dest_y, want.dest_y));
          if (got.src_x !== want.src_x)
            report($sformatf("src_x got %0d want %0d", got.src_x, want.src_x));
          if (got.span_len !== want.span_len)
            report($sformatf("span_len got %0d want %0d", got.span_len, want.span_len));
        end
        // long back-pressure so the block fills and stalls its input
        if (spans_seen == 200 || spans_seen == 1100) rx_wait = 400;
        else rx_wait = calm ? 0 : pick_gap();
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(cfg_idx_t idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic set_layout(int x, int y, int w, int h, int r, int sw, int sh, int srch);
    write_reg(CFG_RECT_X, CW'(x));
    write_reg(CFG_RECT_Y, CW'(y));
    write_reg(CFG_RECT_W, CW'(w));
    write_reg(CFG_RECT_H, CW'(h));
    write_reg(CFG_CORNER_RADIUS, CW'(r));
    write_reg(CFG_SCREEN_WIDTH, CW'(sw));
    write_reg(CFG_SCREEN_HEIGHT, CW'(sh));
    write_reg(CFG_SOURCE_HEIGHT, CW'(srch));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (rows_pending.size() > 0 || in_valid || spans_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_layout();
    int x, y, w, h, r, sw, sh, srch, p, wc;
    p = $urandom_range(99);
    w = (p < 70) ? $urandom_range(0, 300) :
        (p < 90) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
    p = $urandom_range(99);
    h = (p < 70) ? $urandom_range(0, 300) :
        (p < 90) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
    wc = (w > 4096) ? 4096 : w;
    p = $urandom_range(99);
    r = (p < 20) ? 0 :
        (p < 60) ? $urandom_range(0, wc / 2 + 4) :
        (p < 85) ? $urandom_range(0, wc + 8) : $urandom_range(0, 8191);
    p = $urandom_range(99);
    x = (p < 60) ? int'($urandom_range(0, 700)) - 150 : $urandom_range(0, 8191);
    p = $urandom_range(99);
    y = (p < 60) ? int'($urandom_range(0, 500)) - 100 : $urandom_range(0, 8191);
    p = $urandom_range(99);
    sw = (p < 70) ? $urandom_range(1, 1024) : (p < 85) ? 4096 :
         (p < 95) ? $urandom_range(0, 8191) : 0;
    p = $urandom_range(99);
    sh = (p < 70) ? $urandom_range(1, 1024) : (p < 85) ? 4096 :
         (p < 95) ? $urandom_range(0, 8191) : 0;
    p = $urandom_range(99);
    srch = (p < 60) ? h : (p < 80) ? $urandom_range(0, h) : $urandom_range(0, 8191);
    set_layout(x, y, w, h, r, sw, sh, srch);
  endtask

  initial begin
    int fed, n, top;
    fed = 0;
    lay_x = 0; lay_y = 0; lay_w = 0; lay_h = 0; lay_rad = 0;
    scr_w = 0; scr_h = 0; src_h = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset
    rows_pending = '{0, 4095};
    drain();

    // left clip, top cut, source height cut, both corner bands
    set_layout(-10, -5, 100, 80, 20, 640, 480, 70);
    rows_pending = '{0, 5, 19, 20, 40, 60, 69, 70, 80, 4095};
    drain();

    // radius wider than half the width: band decided by unclamped radius
    set_layout(30, 10, 10, 100, 30, 640, 480, 100);
    rows_pending = '{0, 5, 10, 50, 95, 99};
    drain();

    // oversized values saturate; radius ignores bit 12; right clip to last column
    set_layout(4095, 4095, 8191, 8191, 13'h1000, 8191, 8191, 8191);
    rows_pending = '{0, 1, 4095};
    drain();

    // largest radius
    set_layout(0, 0, 4096, 4096, 4095, 4096, 4096, 4096);
    rows_pending = '{0, 2047, 2048, 4095};
    drain();

    // full-width span of the largest size
    set_layout(0, 0, 8191, 4096, 0, 8191, 4096, 4096);
    rows_pending = '{5};
    drain();

    while (fed < RANDOM_ROWS) begin
      random_layout();
      calm = ($urandom_range(4) == 0);
      n = $urandom_range(40, 110);
      top = (lay_h + 8 > 4095) ? 4095 : int'(lay_h) + 8;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 85) rows_pending.push_back(RW'($urandom_range(0, top)));
        else rows_pending.push_back(RW'($urandom_range(0, 4095)));
      end
      fed += n;
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rrsc_pkg.sv
rtl/rrsc_isqrt.sv
rtl/rounded_rect_span_clip.sv
tb/sv/tb.sv
